// ===== hw/rtl/upd_pkg.sv =====
// ============================================================================
// upd_pkg - shared types and constants of the URL percent decoder
// Character codes, escape states, hex digit decode and the queue entry
// that the front hands to the back.
// ============================================================================
`default_nettype none

package upd_pkg;

    localparam int MAX_LEN_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CNT_W  = 12;
    localparam int BYTE_W = 8;
    localparam int RES_W  = 2;

    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [3:0]        HEX_TEN  = 4'd10;

    // escape progress
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    // one decoded step: up to three bytes, or a bare end marker
    typedef struct packed {
        logic [2:0][BYTE_W-1:0] bytes;
        logic [RES_W-1:0]       nres;
        logic                   has_byte;
        logic                   str_end;
        logic                   trunc;
    } t_ent;

    // returns {is_hex, nibble}
    function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        logic [4:0]        r;
        r = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA;
            r = {1'b1, d[3:0] + HEX_TEN};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA;
            r = {1'b1, d[3:0] + HEX_TEN};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/upd_front.sv =====
// ============================================================================
// upd_front - intake and classification
// Accepts one encoded byte per cycle while the queue has room, tracks the
// escape, applies the limit and queues one entry per step that yields results.
// ============================================================================
`default_nettype none

module upd_front import upd_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_in_last,
    input  wire logic              i_cfg_valid,
    input  wire logic [CNT_W-1:0]  i_cfg_out_limit,
    input  wire logic              i_q_not_full,
    output logic                   o_push,
    output t_ent                   o_ent
);

    localparam int CNT_MAX = (2 ** CNT_W) - 1;
    localparam int CAP_INT = ((MAX_LEN - 1) > CNT_MAX) ? CNT_MAX : (MAX_LEN - 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);

    logic [1:0]             r_pend,  n_pend;
    logic [BYTE_W-1:0]      r_held,  n_held;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_drop,  n_drop;
    logic [CNT_W-1:0]       r_limit;

    logic [2:0][BYTE_W-1:0] cand;
    logic [1:0]             ncand;
    logic [1:0]             pend_nx;
    logic [BYTE_W-1:0]      held_nx;
    logic                   plain_go;
    logic [4:0]             hx_c;
    logic [4:0]             hx_h;
    logic [CNT_W-1:0]       lim;
    logic [CNT_W-1:0]       room;
    logic [1:0]             nkeep;
    logic                   accept;

    assign o_in_ready = i_q_not_full;
    assign accept     = i_in_valid && o_in_ready;
    assign hx_c       = hex_val(i_in_byte);
    assign hx_h       = hex_val(r_held);

    // candidate bytes of this step, in order
    always_comb begin
        cand     = '0;
        ncand    = 2'd0;
        pend_nx  = PEND_NONE;
        held_nx  = r_held;
        plain_go = 1'b0;
        unique case (r_pend)
            PEND_PCT: begin
                if (hx_c[4]) begin
                    pend_nx = PEND_DIGIT;
                    held_nx = i_in_byte;
                end else begin
                    cand[0]  = CH_PCT;
                    ncand    = 2'd1;
                    plain_go = 1'b1;
                end
            end
            PEND_DIGIT: begin
                if (hx_c[4]) begin
                    cand[0] = {hx_h[3:0], hx_c[3:0]};
                    ncand   = 2'd1;
                end else begin
                    cand[0]  = CH_PCT;
                    cand[1]  = r_held;
                    ncand    = 2'd2;
                    plain_go = 1'b1;
                end
            end
            default: begin
                plain_go = 1'b1;
            end
        endcase
        if (plain_go) begin
            if (i_in_byte == CH_PCT) begin
                pend_nx = PEND_PCT;
            end else begin
                cand[ncand] = (i_in_byte == CH_PLUS) ? CH_SPACE : i_in_byte;
                ncand       = ncand + 2'd1;
            end
        end
        // flush an escape cut by the end of the string
        if (i_in_last) begin
            if (pend_nx == PEND_PCT) begin
                cand[ncand] = CH_PCT;
                ncand       = ncand + 2'd1;
            end else if (pend_nx == PEND_DIGIT) begin
                cand[0] = CH_PCT;
                cand[1] = held_nx;
                ncand   = 2'd2;
            end
        end
    end

    // keep a prefix of the candidates up to the limit
    always_comb begin
        lim   = (r_limit < CAP) ? r_limit : CAP;
        room  = (r_count < lim) ? (lim - r_count) : '0;
        nkeep = (room < CNT_W'(ncand)) ? room[1:0] : ncand;
    end

    always_comb begin
        o_ent.bytes    = (nkeep == 2'd0) ? '0 : cand;
        o_ent.nres     = (nkeep == 2'd0) ? 2'd1 : nkeep;
        o_ent.has_byte = (nkeep != 2'd0);
        o_ent.str_end  = i_in_last;
        o_ent.trunc    = r_drop || (nkeep != ncand);
        o_push         = accept && (i_in_last || (nkeep != 2'd0));
    end

    always_comb begin
        n_pend  = r_pend;
        n_held  = r_held;
        n_count = r_count;
        n_drop  = r_drop;
        if (accept) begin
            if (i_in_last) begin
                n_pend  = PEND_NONE;
                n_held  = '0;
                n_count = '0;
                n_drop  = 1'b0;
            end else begin
                n_pend  = pend_nx;
                n_held  = held_nx;
                n_count = r_count + CNT_W'(nkeep);
                n_drop  = o_ent.trunc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_held  <= '0;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_limit <= '1;
        end else begin
            r_pend  <= n_pend;
            r_held  <= n_held;
            r_count <= n_count;
            r_drop  <= n_drop;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_out_limit;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/upd_queue.sv =====
// ============================================================================
// upd_queue - step queue between front and back
// Small first-in first-out store of decoded steps.
// ============================================================================
`default_nettype none

module upd_queue import upd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_ent i_ent,
    output logic      o_not_full,
    output logic      o_valid,
    output t_ent      o_head,
    input  wire logic i_pop
);

    localparam int Q_PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(DEPTH + 1);
    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(DEPTH);

    t_ent               r_mem [0:DEPTH-1];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;

    assign o_not_full = (r_count != CNT_FULL);
    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/upd_back.sv =====
// ============================================================================
// upd_back - result serialiser
// Unrolls the head step into single results through a registered output.
// ============================================================================
`default_nettype none

module upd_back import upd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_ent        i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_has_byte,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic             o_run_end,
    output logic             o_string_end,
    output logic             o_truncated
);

    logic             r_valid;
    logic [1:0]       r_idx;
    logic             r_has_byte;
    logic [BYTE_W-1:0] r_byte;
    logic             r_run_end;
    logic             r_str_end;
    logic             r_trunc;
    logic             load;
    logic             at_end;

    assign load   = (!r_valid || i_out_ready) && i_valid;
    assign at_end = (r_idx == (i_head.nres - 2'd1));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_has_byte <= i_head.has_byte;
            r_byte     <= i_head.bytes[r_idx];
            r_run_end  <= at_end;
            r_str_end  <= at_end && i_head.str_end;
            r_trunc    <= i_head.trunc;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_has_byte   = r_has_byte;
    assign o_out_byte   = r_byte;
    assign o_run_end    = r_run_end;
    assign o_string_end = r_str_end;
    assign o_truncated  = r_trunc;

endmodule

`default_nettype wire

// ===== hw/rtl/url_percent_decoder.sv =====
// ============================================================================
// url_percent_decoder - streaming URL percent decoder
// Decodes %hh escapes and '+' into bytes, one encoded byte per item, with a
// per-string limit on kept bytes and a truncation flag.
// ============================================================================
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_byte, i_in_last
//  out     | output    | o_out_valid / i_out_ready  | o_has_byte, o_out_byte, o_run_end,
//          |           |                            | o_string_end, o_truncated
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_out_limit
//
// One input item is taken per cycle while the step queue has room. A step
// yields zero to three results; the output register drains one result per
// cycle while i_out_ready is high, so a bad escape that replays up to three
// bytes holds the input back only once the QUEUE_DEPTH-entry queue has
// filled. Reset is synchronous and clears escape state, counts and the
// queue; the limit returns to 4095. No clearing pass is needed.
// ============================================================================
`default_nettype none

module url_percent_decoder import upd_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_in_byte,
    input  wire logic              i_in_last,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_has_byte,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_run_end,
    output logic                   o_string_end,
    output logic                   o_truncated,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_out_limit
);

    logic q_not_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_ent q_in;
    t_ent q_head;

    // the limit register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // front: accept bytes, follow the escape, apply the limit
    upd_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_out_limit (i_cfg_out_limit),
        .i_q_not_full    (q_not_full),
        .o_push          (q_push),
        .o_ent           (q_in)
    );

    // hold decoded steps until the back takes them
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_ent      (q_in),
        .o_not_full (q_not_full),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    // back: advance through each step one result at a time
    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_has_byte   (o_has_byte),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end),
        .o_truncated  (o_truncated)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top - self-checking bench for the URL percent decoder
// Streams encoded strings into the decoder under random back-pressure on
// both sides, predicts every decoded result in a scoreboard that tracks the
// escape state, kept-byte count and drop flag, and compares each result
// field by field. The output limit is changed between phases while idle.
// ============================================================================

import upd_pkg::*;

typedef struct packed {
    logic              has_byte;
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
    logic              string_end;
    logic              truncated;
} t_dec_result;

class decode_board;
    logic [CNT_W-1:0]  limit;
    logic [1:0]        esc_state;
    logic [BYTE_W-1:0] held_digit;
    logic [CNT_W-1:0]  kept;
    logic              dropped;
    t_dec_result       decoded_q[$];
    t_dec_result       run[3];
    int                run_n;
    int                errors;

    function new();
        limit      = 12'd4095;
        esc_state  = PEND_NONE;
        held_digit = '0;
        kept       = '0;
        dropped    = 1'b0;
        errors     = 0;
    endfunction

    function int nibble_of(logic [BYTE_W-1:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // keep a decoded byte, or drop it once the limit or the run is full
    function void keep_byte(logic [BYTE_W-1:0] b);
        int cap;
        cap = (int'(limit) < MAX_LEN_DEF - 1) ? int'(limit) : MAX_LEN_DEF - 1;
        if (int'(kept) < cap && run_n < 3) begin
            run[run_n] = '{has_byte: 1'b1, out_byte: b, run_end: 1'b0,
                           string_end: 1'b0, truncated: 1'b0};
            run_n++;
            kept = kept + 1'b1;
        end else begin
            dropped = 1'b1;
        end
    endfunction

    function void plain_byte(logic [BYTE_W-1:0] c);
        if (c == CH_PCT)
            esc_state = PEND_PCT;
        else
            keep_byte((c == CH_PLUS) ? CH_SPACE : c);
    endfunction

    // work out the results of one accepted input item
    function void decode_item(logic [BYTE_W-1:0] c, logic last);
        int lo;
        run_n = 0;
        if (esc_state == PEND_PCT) begin
            if (nibble_of(c) >= 0) begin
                held_digit = c;
                esc_state  = PEND_DIGIT;
            end else begin
                esc_state = PEND_NONE;
                keep_byte(CH_PCT);
                plain_byte(c);
            end
        end else if (esc_state == PEND_DIGIT) begin
            lo        = nibble_of(c);
            esc_state = PEND_NONE;
            if (lo >= 0) begin
                keep_byte(BYTE_W'((nibble_of(held_digit) << 4) | lo));
            end else begin
                keep_byte(CH_PCT);
                keep_byte(held_digit);
                plain_byte(c);
            end
        end else begin
            plain_byte(c);
        end

        if (last) begin
            if (esc_state == PEND_PCT) begin
                keep_byte(CH_PCT);
            end else if (esc_state == PEND_DIGIT) begin
                keep_byte(CH_PCT);
                keep_byte(held_digit);
            end
            if (run_n == 0) begin
                run[0] = '0;
                run_n  = 1;
            end
            run[run_n-1].string_end = 1'b1;
        end

        for (int k = 0; k < run_n; k++) begin
            run[k].truncated = dropped;
            if (k == run_n - 1) run[k].run_end = 1'b1;
            decoded_q.push_back(run[k]);
        end

        if (last) begin
            esc_state  = PEND_NONE;
            held_digit = '0;
            kept       = '0;
            dropped    = 1'b0;
        end
    endfunction

    task report_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        errors++;
    endtask

    // compare one accepted result with the oldest prediction
    task match_output(t_dec_result got);
        t_dec_result want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%02h", got.out_byte));
        end else begin
            want = decoded_q.pop_front();
            if (got.has_byte !== want.has_byte)
                report_mismatch($sformatf("has_byte got %b want %b",
                                          got.has_byte, want.has_byte));
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte got %02h want %02h",
                                          got.out_byte, want.out_byte));
            if (got.run_end !== want.run_end)
                report_mismatch($sformatf("run_end got %b want %b",
                                          got.run_end, want.run_end));
            if (got.string_end !== want.string_end)
                report_mismatch($sformatf("string_end got %b want %b",
                                          got.string_end, want.string_end));
            if (got.truncated !== want.truncated)
                report_mismatch($sformatf("truncated got %b want %b",
                                          got.truncated, want.truncated));
        end
    endtask
endclass

module tb_top;

    localparam int DRAIN_CYCLES = 16;   // queue depth plus pipeline, with margin
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int PHASE_ITEMS  = 17;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              out_ready;
    logic              cfg_valid;
    logic [CNT_W-1:0]  cfg_limit;

    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_has_byte;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_run_end;
    logic              o_string_end;
    logic              o_truncated;
    logic              o_cfg_ready;

    decode_board       board;
    logic [BYTE_W-1:0] text_q[$];
    bit                idle_on;
    bit                hold_req;
    int                sent_items;

    url_percent_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (in_byte),
        .i_in_last       (in_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_has_byte      (o_has_byte),
        .o_out_byte      (o_out_byte),
        .o_run_end       (o_run_end),
        .o_string_end    (o_string_end),
        .o_truncated     (o_truncated),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_out_limit (cfg_limit)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one encoded byte and hold it until the decoder takes it. The gap
    // goes before the item, so valid is never dropped and raised in one step.
    task automatic drive_item(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(17, 0) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        board.decode_item(b, last);
        sent_items++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    // send the collected string, marking its final byte, then clear it
    task automatic send_text();
        for (int k = 0; k < text_q.size(); k++)
            drive_item(text_q[k], k == text_q.size() - 1);
        text_q.delete();
    endtask

    // Wait until every predicted result has come out, then give any step
    // that yields nothing time to leave the pipeline.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_limit <= v;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.limit = v;
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input int v);
        if (v < 10) return CH_0 + BYTE_W'(v);
        return ($urandom_range(1, 0) ? CH_UA : CH_LA) + BYTE_W'(v - 10);
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_char();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(255, 0)); while (board.nibble_of(b) >= 0);
        return b;
    endfunction

    // Build one random string: well-formed escapes as the largest share, with
    // broken and cut escapes, plus signs and arbitrary bytes mixed in.
    task automatic build_random_text();
        int pieces;
        int kind;
        int shape;
        pieces = $urandom_range(6, 1);
        repeat (pieces) begin
            kind = $urandom_range(99, 0);
            if (kind < 40) begin
                text_q.push_back(CH_PCT);
                text_q.push_back(hex_char($urandom_range(15, 0)));
                text_q.push_back(hex_char($urandom_range(15, 0)));
            end else if (kind < 52) begin
                shape = $urandom_range(3, 0);
                text_q.push_back(CH_PCT);
                if (shape[0]) text_q.push_back(hex_char($urandom_range(15, 0)));
                if (shape[1]) text_q.push_back(non_hex_char());
            end else if (kind < 62) begin
                text_q.push_back(CH_PLUS);
            end else begin
                text_q.push_back(BYTE_W'($urandom_range(255, 0)));
            end
        end
    endtask

    // Receiver: draw a stall before each result, or take the long hold-off
    // when asked, then accept and check one result.
    initial begin
        int stall;
        out_ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = idle_on ? $urandom_range(17, 0) : 0;
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!o_out_valid) @(posedge clk);
            board.match_output('{has_byte: o_has_byte, out_byte: o_out_byte,
                                 run_end: o_run_end, string_end: o_string_end,
                                 truncated: o_truncated});
        end
    end

    // Stop a run that hangs.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [CNT_W-1:0] limits[9];
        int               phase_items;

        board      = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = '0;
        in_last    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_limit  = '0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        sent_items = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset limit.
        // Hex escape, plus sign, zero byte and all-ones byte in one string.
        add_text("%41+");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text();
        // Second percent inside an escape, then an escape cut after a digit.
        add_text("%%2");
        send_text();
        // Decoded zero byte.
        add_text("%00");
        send_text();
        // Bad second digit: percent, digit and the byte itself in one step.
        add_text("%Fg");
        send_text();
        // Escape cut right after the percent, and after one digit.
        add_text("%");
        send_text();
        add_text("%a");
        send_text();
        // Mixed-case digits.
        add_text("%fA");
        send_text();
        wait_idle();

        // Zero limit: everything dropped, bare end marker flags truncation.
        write_limit('0);
        add_text("a%");
        send_text();
        wait_idle();

        // Limit of one: second byte dropped, bare end marker on the last step.
        write_limit(12'd1);
        add_text("+b");
        send_text();
        wait_idle();

        // Random phases over several limits, the extremes among them.
        limits = '{12'd4095, 12'd0, 12'd2, 12'd1,
                   CNT_W'($urandom_range(12, 0)), 12'd4095,
                   CNT_W'($urandom_range(4095, 0)), 12'd3,
                   CNT_W'($urandom_range(20, 0))};
        foreach (limits[ph]) begin
            write_limit(limits[ph]);
            // Run every third phase without idling; fill the decoder in one.
            idle_on = (ph % 3 != 2);
            if (ph == 2) hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_random_text();
                phase_items += text_q.size();
                send_text();
            end
            wait_idle();
        end

        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
